// ----- sv/lflt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lflt_pkg
// Types, codes and constants for the login failure lockout table.
// ----------------------------------------------------------------------------
package lflt_pkg;

  localparam int LFLT_ENTRIES = 8;

  localparam int ADDR_W = 32;
  localparam int TIME_W = 32;
  localparam int CNT_W  = 8;
  localparam int REM_W  = 17;
  localparam int CFG_W  = 17;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [REM_W-1:0] REM_MAX = {REM_W{1'b1}};

  localparam logic [CNT_W-1:0] MAX_FAILURES_RST    = 8'd5;
  localparam logic [REM_W-1:0] LOCKOUT_SECONDS_RST = 17'd300;

  typedef logic [1:0] op_t;
  localparam op_t OP_CHECK = 2'd0;
  localparam op_t OP_FAIL  = 2'd1;
  localparam op_t OP_RESET = 2'd2;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_MAX_FAILURES    = 1'b0;
  localparam cfg_idx_t CFG_LOCKOUT_SECONDS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  cnt;
    logic [TIME_W-1:0] lock;
  } entry_t;

endpackage

// ----- sv/login_failure_lockout_table.sv -----
// Flow: an accepted item is compared against the entries in ST_SCAN, then
//   committed in ST_UPD; a miss scans every entry, a hit stops at the match.
// Input: no new item is taken until the current one has left ST_UPD; the scan
//   reads the entry memory, one read issued per cycle.
// Reset: clears valid bits, replace pointer and control; config returns to
//   max_failures 5, lockout_seconds 300.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// login_failure_lockout_table
// Per-source-address failed login counter with lockout, held in one entry
// memory that is scanned, modified and written back when the item changes it.
// ----------------------------------------------------------------------------
module login_failure_lockout_table #(
  parameter int ENTRIES = lflt_pkg::LFLT_ENTRIES
) (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_stall,
  input  lflt_pkg::op_t               in_opcode,
  input  logic [lflt_pkg::ADDR_W-1:0] in_ip_addr,
  input  logic [lflt_pkg::TIME_W-1:0] in_now_sec,

  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lflt_pkg::REM_W-1:0]  out_remaining_sec,
  output logic [lflt_pkg::CNT_W-1:0]  out_fail_total,
  output logic                        out_lockout_armed,
  output logic                        out_entry_hit,

  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  lflt_pkg::cfg_idx_t          cfg_index,
  input  logic [lflt_pkg::CFG_W-1:0]  cfg_data
);

  import lflt_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] max_fail_r;
  logic [REM_W-1:0] lock_sec_r;

  op_t               op_r;
  logic [ADDR_W-1:0] ip_r;
  logic [TIME_W-1:0] now_r;

  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [IW-1:0]      ptr_r, ptr_nxt;

  entry_t        ent_mem_r [ENTRIES];
  entry_t        rdata_r;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic          rd_more_r, rd_more_nxt;
  logic          cmp_v_r;
  logic [IW-1:0] cmp_idx_r;

  logic          hit_r, hit_nxt;
  logic [IW-1:0] slot_r, slot_nxt;
  entry_t        ent_r, ent_nxt;
  logic          free_found_r, free_found_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;

  logic              out_valid_r;
  logic [REM_W-1:0]  out_rem_r;
  logic [CNT_W-1:0]  out_total_r;
  logic              out_armed_r;
  logic              out_hit_r;

  logic              in_take;
  logic              out_free;
  logic              commit;
  logic              match;
  logic              scan_miss;

  logic [IW-1:0]     ptr_adv;
  logic [IW-1:0]     wr_slot;
  logic              we;
  entry_t            wdata;
  entry_t            cur;
  logic [CNT_W-1:0]  cnt_inc;
  logic              arm;
  logic [TIME_W-1:0] lock_sum;
  logic              lock_set;
  logic              still_locked;
  logic [TIME_W-1:0] lock_diff;
  logic [REM_W-1:0]  rem_val;
  logic [REM_W-1:0]  res_rem;
  logic [CNT_W-1:0]  res_total;
  logic              res_armed;
  logic              res_hit;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign commit    = (state_r == ST_UPD) && out_free;
  assign cfg_ready = 1'b1;

  assign match     = cmp_v_r && valid_r[cmp_idx_r] && (rdata_r.addr == ip_r);
  assign scan_miss = cmp_v_r && !match && (cmp_idx_r == LAST);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_take) state_nxt = ST_SCAN;
      ST_SCAN: if (match || scan_miss) state_nxt = ST_UPD;
      ST_UPD:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Scan control and match capture
  always_comb begin
    rd_idx_nxt     = rd_idx_r;
    rd_more_nxt    = rd_more_r;
    hit_nxt        = hit_r;
    slot_nxt       = slot_r;
    ent_nxt        = ent_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        rd_idx_nxt     = '0;
        rd_more_nxt    = 1'b1;
        hit_nxt        = 1'b0;
        free_found_nxt = 1'b0;
        ent_nxt        = '0;
      end
      ST_SCAN: begin
        if (rd_more_r) begin
          if (rd_idx_r == LAST) begin
            rd_more_nxt = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
        end
        if (cmp_v_r && !valid_r[cmp_idx_r] && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = cmp_idx_r;
        end
        if (match) begin
          hit_nxt  = 1'b1;
          slot_nxt = cmp_idx_r;
          ent_nxt  = rdata_r;
        end
      end
      ST_UPD: begin
      end
      default: begin
      end
    endcase
  end

  // Read-modify-write datapath
  always_comb begin
    ptr_adv      = (ptr_r == LAST) ? '0 : ptr_r + 1'b1;
    wr_slot      = hit_r ? slot_r : (free_found_r ? free_idx_r : ptr_adv);
    cur          = hit_r ? ent_r : '0;
    cnt_inc      = (cur.cnt != CNT_MAX) ? cur.cnt + 1'b1 : cur.cnt;
    arm          = (cnt_inc >= max_fail_r);
    lock_sum     = now_r + TIME_W'(lock_sec_r);
    lock_set     = (cur.lock != '0);
    still_locked = (now_r < cur.lock);
    lock_diff    = cur.lock - now_r;
    rem_val      = (lock_diff > TIME_W'(REM_MAX)) ? REM_MAX : lock_diff[REM_W-1:0];

    we        = 1'b0;
    wdata     = '{addr: ip_r, cnt: '0, lock: '0};
    valid_nxt = valid_r;
    ptr_nxt   = ptr_r;
    res_rem   = '0;
    res_total = '0;
    res_armed = 1'b0;
    res_hit   = 1'b0;

    case (op_r)
      OP_CHECK: begin
        if (hit_r) begin
          res_hit   = 1'b1;
          res_total = cur.cnt;
          if (lock_set) begin
            if (still_locked) begin
              res_rem = rem_val;
            end else begin
              we        = 1'b1;
              res_total = '0;
            end
          end
        end
      end
      OP_FAIL: begin
        we        = 1'b1;
        res_hit   = hit_r;
        res_total = cnt_inc;
        wdata.cnt = cnt_inc;
        wdata.lock = cur.lock;
        if (arm) begin
          wdata.lock = lock_sum;
          res_armed  = 1'b1;
        end
        valid_nxt[wr_slot] = 1'b1;
        if (!hit_r && !free_found_r) ptr_nxt = ptr_adv;
      end
      OP_RESET: begin
        if (hit_r) begin
          we      = 1'b1;
          res_hit = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      max_fail_r   <= MAX_FAILURES_RST;
      lock_sec_r   <= LOCKOUT_SECONDS_RST;
      valid_r      <= '0;
      ptr_r        <= '0;
      rd_more_r    <= 1'b0;
      cmp_v_r      <= 1'b0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_more_r    <= rd_more_nxt;
      cmp_v_r      <= (state_r == ST_SCAN) && rd_more_r && !match;
      hit_r        <= hit_nxt;
      free_found_r <= free_found_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_MAX_FAILURES:    max_fail_r <= cfg_data[CNT_W-1:0];
          CFG_LOCKOUT_SECONDS: lock_sec_r <= cfg_data[REM_W-1:0];
          default: ;
        endcase
      end
      if (commit) begin
        valid_r <= valid_nxt;
        ptr_r   <= ptr_nxt;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    cmp_idx_r  <= rd_idx_r;
    slot_r     <= slot_nxt;
    ent_r      <= ent_nxt;
    free_idx_r <= free_idx_nxt;
    if (in_take) begin
      op_r  <= in_opcode;
      ip_r  <= in_ip_addr;
      now_r <= in_now_sec;
    end
    if (commit) begin
      out_rem_r   <= res_rem;
      out_total_r <= res_total;
      out_armed_r <= res_armed;
      out_hit_r   <= res_hit;
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (commit && we) ent_mem_r[wr_slot] <= wdata;
    rdata_r <= ent_mem_r[rd_idx_r];
  end

  assign out_valid         = out_valid_r;
  assign out_remaining_sec = out_rem_r;
  assign out_fail_total    = out_total_r;
  assign out_lockout_armed = out_armed_r;
  assign out_entry_hit     = out_hit_r;

`ifndef ASSERT_OFF
  a_take_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> state_r == ST_SCAN)
    else $error("accepted item did not start a scan");

  a_hit_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) && hit_r |-> valid_r[slot_r])
    else $error("hit on an entry that is not valid");

  a_armed_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_lockout_armed |-> out_fail_total != '0)
    else $error("lockout armed with zero failure count");

  a_rem_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_remaining_sec != '0) |-> out_entry_hit)
    else $error("remaining time reported without a hit");

  a_result_from_upd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_UPD))
    else $error("result raised outside the update step");
`endif

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the login failure lockout table. A short table of
// directed attempts, then randomised phases over several threshold and
// lockout settings, each accepted item run through a local table model and
// every result compared field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import lflt_pkg::*;

  localparam op_t OP_UNUSED   = 2'd3;
  localparam int  DRAIN_CYC   = 2 * LFLT_ENTRIES + 4;
  localparam int  LONG_HOLD   = 80;
  localparam int  CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [REM_W-1:0] remaining;
    logic [CNT_W-1:0] total;
    logic             armed;
    logic             hit;
  } lockout_res_t;

  typedef enum logic {ROW_ATTEMPT, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] now;
    bit                typed;
    lockout_res_t      want;
    cfg_idx_t          idx;
    logic [CFG_W-1:0]  data;
  } plan_row_t;

  localparam lockout_res_t NOTHING = '0;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  op_t               in_opcode;
  logic [ADDR_W-1:0] in_ip_addr;
  logic [TIME_W-1:0] in_now_sec;
  logic              out_valid;
  logic              out_stall;
  logic [REM_W-1:0]  out_remaining_sec;
  logic [CNT_W-1:0]  out_fail_total;
  logic              out_lockout_armed;
  logic              out_entry_hit;
  logic              cfg_valid;
  logic              cfg_ready;
  cfg_idx_t          cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  login_failure_lockout_table dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_ip_addr       (in_ip_addr),
    .in_now_sec       (in_now_sec),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_remaining_sec(out_remaining_sec),
    .out_fail_total   (out_fail_total),
    .out_lockout_armed(out_lockout_armed),
    .out_entry_hit    (out_entry_hit),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // table model
  logic              seen_valid   [LFLT_ENTRIES];
  logic [ADDR_W-1:0] seen_addr    [LFLT_ENTRIES];
  logic [CNT_W-1:0]  seen_count   [LFLT_ENTRIES];
  logic [TIME_W-1:0] locked_until [LFLT_ENTRIES];
  int                evict_ptr;
  logic [CNT_W-1:0]  max_fail_cfg;
  logic [CFG_W-1:0]  lock_len_cfg;

  lockout_res_t pending [$];
  plan_row_t    plan [$];

  int errors       = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int reg_writes   = 0;
  int cycles       = 0;
  int idle_pct;
  bit long_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic void clear_model();
    int i;
    for (i = 0; i < LFLT_ENTRIES; i++) begin
      seen_valid[i]   = 1'b0;
      seen_addr[i]    = '0;
      seen_count[i]   = '0;
      locked_until[i] = '0;
    end
    evict_ptr    = 0;
    max_fail_cfg = MAX_FAILURES_RST;
    lock_len_cfg = LOCKOUT_SECONDS_RST;
  endfunction

  function automatic lockout_res_t apply_attempt(op_t op, logic [ADDR_W-1:0] addr,
                                                 logic [TIME_W-1:0] now);
    lockout_res_t      r;
    int                slot;
    int                i;
    logic [TIME_W-1:0] left;
    r    = '0;
    slot = -1;
    for (i = 0; i < LFLT_ENTRIES; i++)
      if (slot < 0 && seen_valid[i] && seen_addr[i] == addr) slot = i;
    case (op)
      OP_CHECK: begin
        if (slot >= 0) begin
          r.hit = 1'b1;
          if (locked_until[slot] != '0) begin
            if (now < locked_until[slot]) begin
              left = locked_until[slot] - now;
              r.remaining = (left > REM_MAX) ? REM_MAX : left[REM_W-1:0];
            end else begin
              locked_until[slot] = '0;
              seen_count[slot]   = '0;
            end
          end
          r.total = seen_count[slot];
        end
      end
      OP_FAIL: begin
        if (slot >= 0) begin
          r.hit = 1'b1;
        end else begin
          for (i = 0; i < LFLT_ENTRIES; i++)
            if (slot < 0 && !seen_valid[i]) slot = i;
          if (slot < 0) begin
            evict_ptr = (evict_ptr + 1) % LFLT_ENTRIES;
            slot      = evict_ptr;
          end
          seen_valid[slot]   = 1'b1;
          seen_addr[slot]    = addr;
          seen_count[slot]   = '0;
          locked_until[slot] = '0;
        end
        if (seen_count[slot] != CNT_MAX) seen_count[slot] = seen_count[slot] + 8'd1;
        if (seen_count[slot] >= max_fail_cfg) begin
          locked_until[slot] = now + lock_len_cfg;
          r.armed = 1'b1;
        end
        r.total = seen_count[slot];
      end
      OP_RESET: begin
        if (slot >= 0) begin
          r.hit              = 1'b1;
          seen_count[slot]   = '0;
          locked_until[slot] = '0;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic plan_row_t attempt_row(op_t op, logic [ADDR_W-1:0] addr,
                                            logic [TIME_W-1:0] now, bit typed,
                                            lockout_res_t want);
    plan_row_t r;
    r.kind  = ROW_ATTEMPT;
    r.op    = op;
    r.addr  = addr;
    r.now   = now;
    r.typed = typed;
    r.want  = want;
    r.idx   = CFG_MAX_FAILURES;
    r.data  = '0;
    return r;
  endfunction

  function automatic plan_row_t reg_row(cfg_idx_t idx, logic [CFG_W-1:0] data);
    plan_row_t r;
    r.kind  = ROW_REG;
    r.op    = OP_CHECK;
    r.addr  = '0;
    r.now   = '0;
    r.typed = 1'b0;
    r.want  = NOTHING;
    r.idx   = idx;
    r.data  = data;
    return r;
  endfunction

  task automatic note_mismatch(string what, int unsigned got, int unsigned want);
    errors++;
    $display("mismatch on %s at result %0d: got %0d, expected %0d",
             what, results_seen, got, want);
  endtask

  always @(posedge clk) begin : result_check
    lockout_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        note_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending.pop_front();
        if (out_remaining_sec !== want.remaining)
          note_mismatch("remaining_sec", out_remaining_sec, want.remaining);
        if (out_fail_total !== want.total)
          note_mismatch("fail_total", out_fail_total, want.total);
        if (out_lockout_armed !== want.armed)
          note_mismatch("lockout_armed", out_lockout_armed, want.armed);
        if (out_entry_hit !== want.hit)
          note_mismatch("entry_hit", out_entry_hit, want.hit);
      end
      results_seen++;
    end
  end

  initial begin : result_sink
    int burst;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold = 1'b0;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        burst = $urandom_range(1, 4);
        out_stall <= 1'b1;
        repeat (burst) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic offer_attempt(op_t op, logic [ADDR_W-1:0] addr, logic [TIME_W-1:0] now,
                               bit typed, lockout_res_t want);
    int           gap;
    lockout_res_t got;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_ip_addr <= addr;
    in_now_sec <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = apply_attempt(op, addr, now);
    pending.push_back(typed ? want : got);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_MAX_FAILURES) max_fail_cfg = data[CNT_W-1:0];
    else lock_len_cfg = data;
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic [CNT_W-1:0] thr, logic [CFG_W-1:0] lock_len, int n,
                           int pool_n, int fail_pct, int idle, bit press);
    logic [ADDR_W-1:0] pool [$];
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] t;
    op_t               op;
    int                k;
    int                r;
    write_reg(CFG_MAX_FAILURES, {{(CFG_W-CNT_W){1'b0}}, thr});
    write_reg(CFG_LOCKOUT_SECONDS, lock_len);
    idle_pct = idle;
    r = $urandom_range(0, 2);
    pool.push_back(r == 0 ? '0 : (r == 1 ? '1 : ADDR_W'($urandom)));
    for (k = 1; k < pool_n; k++) pool.push_back($urandom);
    t = $urandom;
    if (press) long_hold = 1'b1;
    for (k = 0; k < n; k++) begin
      if (press && k == n / 2) settle();
      r = $urandom_range(0, 99);
      if (r < 70) t = t + $urandom_range(0, lock_len);
      else if (r < 85) t = t + $urandom_range(0, 3);
      else if (r < 93) t = $urandom;
      else t = t - $urandom_range(0, 1000);
      if ($urandom_range(0, 99) < fail_pct) begin
        op = OP_FAIL;
      end else begin
        r = $urandom_range(0, 9);
        op = (r < 7) ? OP_CHECK : (r < 9 ? OP_RESET : OP_UNUSED);
      end
      if (pool_n > 1 && $urandom_range(0, 9) == 0) addr = $urandom;
      else addr = pool[$urandom_range(0, pool_n - 1)];
      offer_attempt(op, addr, t, 1'b0, NOTHING);
    end
  endtask

  initial begin : main
    int k;
    in_valid   = 1'b0;
    in_opcode  = OP_CHECK;
    in_ip_addr = '0;
    in_now_sec = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_MAX_FAILURES;
    cfg_data   = '0;
    rst_n      = 1'b0;
    idle_pct   = 0;
    long_hold  = 1'b0;
    clear_model();

    plan.push_back(attempt_row(OP_CHECK,  32'h0000_0000, 32'd0, 1, NOTHING));
    plan.push_back(attempt_row(OP_RESET,  32'hFFFF_FFFF, 32'd0, 1, NOTHING));
    plan.push_back(attempt_row(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, NOTHING));
    plan.push_back(attempt_row(OP_FAIL, 32'hFFFF_FFFF, 32'd100, 1, {17'd0, 8'd1, 1'b0, 1'b0}));
    plan.push_back(attempt_row(OP_FAIL, 32'hFFFF_FFFF, 32'd101, 1, {17'd0, 8'd2, 1'b0, 1'b1}));
    plan.push_back(attempt_row(OP_FAIL, 32'hFFFF_FFFF, 32'd102, 1, {17'd0, 8'd3, 1'b0, 1'b1}));
    plan.push_back(attempt_row(OP_FAIL, 32'hFFFF_FFFF, 32'd103, 1, {17'd0, 8'd4, 1'b0, 1'b1}));
    plan.push_back(attempt_row(OP_FAIL, 32'hFFFF_FFFF, 32'd104, 1, {17'd0, 8'd5, 1'b1, 1'b1}));
    plan.push_back(attempt_row(OP_CHECK, 32'hFFFF_FFFF, 32'd104, 1,
                               {17'd300, 8'd5, 1'b0, 1'b1}));
    plan.push_back(attempt_row(OP_CHECK, 32'hFFFF_FFFF, 32'd404, 1, {17'd0, 8'd0, 1'b0, 1'b1}));
    plan.push_back(attempt_row(OP_RESET, 32'hFFFF_FFFF, 32'd405, 1, {17'd0, 8'd0, 1'b0, 1'b1}));
    plan.push_back(reg_row(CFG_MAX_FAILURES, 17'd0));
    plan.push_back(reg_row(CFG_LOCKOUT_SECONDS, 17'd86400));
    plan.push_back(attempt_row(OP_FAIL, 32'h0000_0000, 32'h8000_0000, 1,
                               {17'd0, 8'd1, 1'b1, 1'b0}));
    plan.push_back(attempt_row(OP_CHECK, 32'h0000_0000, 32'd5, 1, {REM_MAX, 8'd1, 1'b0, 1'b1}));
    plan.push_back(attempt_row(OP_FAIL, 32'h0000_0000, 32'hFFFE_AE80, 1,
                               {17'd0, 8'd2, 1'b1, 1'b1}));
    plan.push_back(attempt_row(OP_CHECK, 32'h0000_0000, 32'd7, 1, {17'd0, 8'd2, 1'b0, 1'b1}));
    plan.push_back(reg_row(CFG_MAX_FAILURES, 17'd255));
    plan.push_back(reg_row(CFG_LOCKOUT_SECONDS, 17'd1));
    for (k = 1; k <= 6; k++)
      plan.push_back(attempt_row(OP_FAIL, 32'h0A00_0000 + k, 32'd1000, 0, NOTHING));
    plan.push_back(attempt_row(OP_FAIL, 32'hC0A8_0001, 32'd1000, 0, NOTHING));
    plan.push_back(attempt_row(OP_CHECK, 32'h0000_0000, 32'd1001, 1, NOTHING));
    plan.push_back(attempt_row(OP_CHECK, 32'hFFFF_FFFF, 32'd1001, 1, {17'd0, 8'd0, 1'b0, 1'b1}));

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    idle_pct = 20;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) write_reg(plan[i].idx, plan[i].data);
      else offer_attempt(plan[i].op, plan[i].addr, plan[i].now, plan[i].typed, plan[i].want);
    end

    run_phase(8'd5,   17'd300,    70,  6, 50, 30, 1'b0);
    run_phase(8'd1,   17'd1,      70, 12, 45, 15, 1'b0);
    run_phase(8'd255, 17'd100,   270,  1, 100, 25, 1'b0);
    run_phase(8'd0,   17'h1FFFF,  60, 10, 50,  0, 1'b0);
    run_phase(CNT_W'($urandom_range(1, 8)), CFG_W'($urandom_range(1, 131071)),
              70, 9, 55, 20, 1'b1);
    run_phase(CNT_W'($urandom_range(2, 6)), CFG_W'($urandom_range(1, 2000)),
              70, 11, 50, 0, 1'b0);
    settle();

    $display("summary: %0d items offered, %0d results checked, %0d register writes",
             items_sent, results_seen, reg_writes);
    $display("summary: misses, expiry, wrap, saturation, eviction and back-pressure covered");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
